[rtl/indexed_list_shift_store_core_defines.svh]
// assertion macros shared by the indexed list store rtl
// no dependencies; included by files that carry concurrent checks
`ifndef INDEXED_LIST_SHIFT_STORE_CORE_DEFINES_SVH
`define INDEXED_LIST_SHIFT_STORE_CORE_DEFINES_SVH

// same-cycle implication, checks off while in reset
`define ILSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checks off while in reset
`define ILSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ilss_pkg.sv]
// shared types, codes and sizing functions for the indexed list store
// no dependencies; imported by every module of the block
`default_nettype none

package ilss_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int ITEM_WIDTH_DEF = 32;

  localparam int CMD_W       = 3;
  localparam int POS_W       = 10;
  localparam int ITEM_IO_W   = 32;
  localparam int STATUS_W    = 2;
  localparam int LEN_OUT_W   = 11;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ITEM_IO_W - LEN_OUT_W;

  // widest cell index the op struct can carry (capacity up to 65536)
  localparam int MAX_IDX_W = 16;

  // read tree fan-in per level
  localparam int TREE_RADIX_LOG = 4;
  localparam int TREE_RADIX     = 1 << TREE_RADIX_LOG;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_APPEND    = 3'd0;
  localparam cmd_t CMD_POP       = 3'd1;
  localparam cmd_t CMD_READ      = 3'd2;
  localparam cmd_t CMD_OVERWRITE = 3'd3;
  localparam cmd_t CMD_INSERT    = 3'd4;
  localparam cmd_t CMD_REMOVE    = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  // broadcast to every cell during the execute cycle
  typedef struct packed {
    logic                 wr;      // write word at pos
    logic                 ins;     // shift up above pos, write word at pos
    logic                 rem;     // shift down from pos
    logic                 rd;      // capture entry at rd_pos for the read tree
    logic [MAX_IDX_W-1:0] pos;
    logic [MAX_IDX_W-1:0] rd_pos;
  } cell_op_t;

  function automatic int tree_levels(input int leaves);
    int lv;
    lv = ($clog2(leaves) + TREE_RADIX_LOG - 1) / TREE_RADIX_LOG;
    if (lv < 1) begin
      lv = 1;
    end
    return lv;
  endfunction

  // offset of the first node of a level in the flat node array (level 1 at 0)
  function automatic int tree_off(input int pad, input int lvl);
    int off;
    off = 0;
    for (int k = 1; k < lvl; k++) begin
      off += pad >> (TREE_RADIX_LOG * k);
    end
    return off;
  endfunction

endpackage

`default_nettype wire

[rtl/indexed_list_shift_store_core.sv]
// indexed list store: a row of entry cells, a control sequencer and a registered read tree
// depends on ilss_pkg, ilss_cell, ilss_or_tree and the assertion macro header
//
// usage
//   in_*  request channel: in_tuser carries the command (append, pop, read, overwrite,
//         insert, remove), in_tdata the position and the item word
//   out_* result channel: out_tuser carries the status (ok, out of range, empty, full),
//         out_tdata the returned word and the list length after the request
//   every request gives exactly one result
// timing
//   in the execute state every cell shifts, writes or holds in the same edge, so insert
//   and remove cost the same as append; the read word then climbs a radix-16 registered
//   or tree of ceil(log16(CAPACITY)) levels (3 for 1024 entries)
//   out_tvalid rises as the sequencer leaves the finish state once the tree has drained;
//   a new request is taken only when the sequencer is back in idle
// reset
//   rst_n low empties the list and drops any pending result; entry words are not cleared,
//   only positions below the length are ever read
// stalls
//   the result sits in an output register; the next request is taken while it waits, and
//   the finished result of that request holds in the tree until the register frees up
`default_nettype none
`include "indexed_list_shift_store_core_defines.svh"

module indexed_list_shift_store_core #(
  parameter int CAPACITY   = ilss_pkg::CAPACITY_DEF,
  parameter int ITEM_WIDTH = ilss_pkg::ITEM_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // request channel
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [ilss_pkg::IN_TDATA_W-1:0]  in_tdata,   // position[9:0], item_in[41:10]
  input  wire  [ilss_pkg::CMD_W-1:0]       in_tuser,   // command[2:0]
  // result channel
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [ilss_pkg::OUT_TDATA_W-1:0] out_tdata,  // item_out[31:0], length_out[42:32]
  output logic [ilss_pkg::STATUS_W-1:0]    out_tuser   // status[1:0]
);
  import ilss_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int XW     = (ITEM_WIDTH > ITEM_IO_W) ? ITEM_WIDTH : ITEM_IO_W;
  localparam int LXW    = (LEN_W > LEN_OUT_W) ? LEN_W : LEN_OUT_W;
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int CNT_W  = $clog2(LEVELS + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  // control state
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             out_valid_r, out_valid_nxt;

  // request and result payload
  cmd_t                  req_cmd_r;
  logic [POS_W-1:0]      req_pos_r;
  logic [ITEM_WIDTH-1:0] req_word_r;
  status_t               status_r, status_nxt;
  logic                  word_flag_r, word_flag_nxt;
  logic [ITEM_IO_W-1:0]  out_item_r, out_item_nxt;
  status_t               out_status_r;
  logic [LEN_OUT_W-1:0]  out_len_r, out_len_nxt;

  // request unpacking
  cmd_t                  in_cmd;
  logic [POS_W-1:0]      in_pos;
  logic [ITEM_IO_W-1:0]  in_item;
  logic [XW-1:0]         in_item_ext;
  logic [ITEM_WIDTH-1:0] in_word;

  assign in_cmd      = in_tuser;
  assign in_pos      = in_tdata[POS_W-1:0];
  assign in_item     = in_tdata[POS_W +: ITEM_IO_W];
  assign in_item_ext = XW'(in_item);
  assign in_word     = in_item_ext[ITEM_WIDTH-1:0];

  logic req_take;
  logic out_free;

  // no request is taken while reset is held
  assign in_tready = (state_r == S_IDLE) && rst_n;
  assign req_take  = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // execute decode
  cell_op_t         op;
  logic [CMP_W-1:0] pos_cmp, len_cmp;
  logic             in_range, is_empty, is_full;
  logic [IDX_W-1:0] pos_idx, len_idx, last_idx;

  assign pos_cmp  = CMP_W'(req_pos_r);
  assign len_cmp  = CMP_W'(len_r);
  assign in_range = pos_cmp < len_cmp;
  assign is_empty = (len_r == '0);
  assign is_full  = (len_r == LEN_W'(CAPACITY));
  assign pos_idx  = IDX_W'(req_pos_r);
  assign len_idx  = IDX_W'(len_r);
  assign last_idx = IDX_W'(len_r - LEN_W'(1));

  always_comb begin
    op            = '0;
    len_nxt       = len_r;
    status_nxt    = status_r;
    word_flag_nxt = word_flag_r;
    if (state_r == S_EXEC) begin
      status_nxt    = ST_OK;
      word_flag_nxt = 1'b0;
      unique case (req_cmd_r)
        CMD_APPEND: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            op.wr   = 1'b1;
            op.pos  = MAX_IDX_W'(len_idx);
            len_nxt = len_r + LEN_W'(1);
          end
        end
        CMD_POP: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            op.rd         = 1'b1;
            op.rd_pos     = MAX_IDX_W'(last_idx);
            word_flag_nxt = 1'b1;
            len_nxt       = len_r - LEN_W'(1);
          end
        end
        CMD_READ: begin
          if (!in_range) begin
            status_nxt = ST_RANGE;
          end else begin
            op.rd         = 1'b1;
            op.rd_pos     = MAX_IDX_W'(pos_idx);
            word_flag_nxt = 1'b1;
          end
        end
        CMD_OVERWRITE: begin
          if (!in_range) begin
            status_nxt = ST_RANGE;
          end else begin
            op.wr  = 1'b1;
            op.pos = MAX_IDX_W'(pos_idx);
          end
        end
        CMD_INSERT: begin
          // an empty list takes the word at the front, position ignored
          if (is_empty) begin
            op.wr   = 1'b1;
            op.pos  = '0;
            len_nxt = LEN_W'(1);
          end else if (!in_range) begin
            status_nxt = ST_RANGE;
          end else if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            op.ins  = 1'b1;
            op.pos  = MAX_IDX_W'(pos_idx);
            len_nxt = len_r + LEN_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else if (!in_range) begin
            status_nxt = ST_RANGE;
          end else begin
            op.rem        = 1'b1;
            op.pos        = MAX_IDX_W'(pos_idx);
            op.rd         = 1'b1;
            op.rd_pos     = MAX_IDX_W'(pos_idx);
            word_flag_nxt = 1'b1;
            len_nxt       = len_r - LEN_W'(1);
          end
        end
        default: begin
          // unused commands leave the list as is and report ok
        end
      endcase
    end
  end

  // row of cells
  logic [ITEM_WIDTH-1:0] cell_q [CAPACITY];
  logic [ITEM_WIDTH-1:0] rd_q   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] prev_w, next_w;
    if (i == 0) begin : g_head
      assign prev_w = cell_q[0];
    end else begin : g_body
      assign prev_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_w = cell_q[i];
    end else begin : g_mid
      assign next_w = cell_q[i+1];
    end
    ilss_cell #(
      .ITEM_WIDTH (ITEM_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .wr_word (req_word_r),
      .prev_q  (prev_w),
      .next_q  (next_w),
      .data_q  (cell_q[i]),
      .rd_q    (rd_q[i])
    );
  end

  // read word collection
  logic [ITEM_WIDTH-1:0] root_w;
  logic [XW-1:0]         root_ext;

  ilss_or_tree #(
    .ITEM_WIDTH (ITEM_WIDTH),
    .LEAVES     (CAPACITY)
  ) u_tree (
    .clk    (clk),
    .leaf_i (rd_q),
    .root_o (root_w)
  );

  assign root_ext = XW'(root_w);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DRAIN;
        cnt_nxt   = '0;
      end
      S_DRAIN: begin
        if (cnt_r == CNT_W'(LEVELS - 1)) begin
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  logic [LXW-1:0] len_ext;

  assign len_ext      = LXW'(len_r);
  assign out_len_nxt  = len_ext[LEN_OUT_W-1:0];
  assign out_item_nxt = word_flag_r ? root_ext[ITEM_IO_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      req_cmd_r  <= in_cmd;
      req_pos_r  <= in_pos;
      req_word_r <= in_word;
    end
    status_r    <= status_nxt;
    word_flag_r <= word_flag_nxt;
    if (state_r == S_FINISH && out_free) begin
      out_item_r   <= out_item_nxt;
      out_status_r <= status_r;
      out_len_r    <= out_len_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_len_r, out_item_r};
  assign out_tuser  = out_status_r;

  // checks
  `ILSS_ASSERT_NEXT(a_take_goes_exec, clk, rst_n, req_take,
    (state_r == S_EXEC) && !in_tready, "request taken but sequencer not executing")
  `ILSS_ASSERT_IMPLY(a_len_bound, clk, rst_n, 1'b1,
    len_r <= LEN_W'(CAPACITY), "list length beyond capacity")
  `ILSS_ASSERT_IMPLY(a_empty_len, clk, rst_n, out_valid_r && (out_status_r == ST_EMPTY),
    out_len_r == '0, "empty status with nonzero length")
  `ILSS_ASSERT_NEXT(a_finish_posts, clk, rst_n, (state_r == S_FINISH) && out_free,
    out_valid_r && (state_r == S_IDLE), "finished request not posted")

endmodule

`default_nettype wire

[rtl/ilss_cell.sv]
// one list entry: holds a word, shifts with its neighbors, offers it to the read tree
// depends on ilss_pkg
`default_nettype none

module ilss_cell #(
  parameter int ITEM_WIDTH = 32,
  parameter int IDX_W      = 10,
  parameter int INDEX      = 0
) (
  input  wire                     clk,
  input  ilss_pkg::cell_op_t      op,
  input  wire  [ITEM_WIDTH-1:0]   wr_word,
  input  wire  [ITEM_WIDTH-1:0]   prev_q,
  input  wire  [ITEM_WIDTH-1:0]   next_q,
  output logic [ITEM_WIDTH-1:0]   data_q,
  output logic [ITEM_WIDTH-1:0]   rd_q
);
  import ilss_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [ITEM_WIDTH-1:0] data_r, data_nxt;
  logic [ITEM_WIDTH-1:0] rd_r, rd_nxt;
  logic [IDX_W-1:0]      pos, rd_pos;

  assign pos    = op.pos[IDX_W-1:0];
  assign rd_pos = op.rd_pos[IDX_W-1:0];

  always_comb begin
    priority if (op.ins && (MY_IDX > pos)) begin
      data_nxt = prev_q;
    end else if ((op.ins || op.wr) && (MY_IDX == pos)) begin
      data_nxt = wr_word;
    end else if (op.rem && (MY_IDX >= pos)) begin
      data_nxt = next_q;
    end else begin
      data_nxt = data_r;
    end
  end

  // zero unless selected, so the tree can simply or everything together
  always_comb begin
    if (op.rd) begin
      rd_nxt = (MY_IDX == rd_pos) ? data_r : '0;
    end else begin
      rd_nxt = rd_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    rd_r   <= rd_nxt;
  end

  assign data_q = data_r;
  assign rd_q   = rd_r;

endmodule

`default_nettype wire

[rtl/ilss_or_tree.sv]
// registered radix-16 or tree that collects the one selected cell word
// depends on ilss_pkg
`default_nettype none

module ilss_or_tree #(
  parameter int ITEM_WIDTH = 32,
  parameter int LEAVES     = 1024
) (
  input  wire                   clk,
  input  wire  [ITEM_WIDTH-1:0] leaf_i [LEAVES],
  output logic [ITEM_WIDTH-1:0] root_o
);
  import ilss_pkg::*;

  localparam int LEVELS = tree_levels(LEAVES);
  localparam int PAD    = 1 << (TREE_RADIX_LOG * LEVELS);
  localparam int NODES  = tree_off(PAD, LEVELS + 1);

  logic [ITEM_WIDTH-1:0] pad_w  [PAD];
  logic [ITEM_WIDTH-1:0] node_r [NODES];

  for (genvar k = 0; k < PAD; k++) begin : g_pad
    if (k < LEAVES) begin : g_used
      assign pad_w[k] = leaf_i[k];
    end else begin : g_zero
      assign pad_w[k] = '0;
    end
  end

  for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_lvl
    localparam int NCNT = PAD >> (TREE_RADIX_LOG * lv);
    localparam int OFF  = tree_off(PAD, lv);
    localparam int COFF = tree_off(PAD, lv - 1);
    for (genvar j = 0; j < NCNT; j++) begin : g_node
      logic [ITEM_WIDTH-1:0] acc_nxt;
      if (lv == 1) begin : g_first
        always_comb begin
          acc_nxt = '0;
          for (int c = 0; c < TREE_RADIX; c++) begin
            acc_nxt = acc_nxt | pad_w[j*TREE_RADIX + c];
          end
        end
      end else begin : g_inner
        always_comb begin
          acc_nxt = '0;
          for (int c = 0; c < TREE_RADIX; c++) begin
            acc_nxt = acc_nxt | node_r[COFF + j*TREE_RADIX + c];
          end
        end
      end
      always_ff @(posedge clk) begin
        node_r[OFF + j] <= acc_nxt;
      end
    end
  end

  assign root_o = node_r[NODES-1];

endmodule

`default_nettype wire
